// ===== design/gcpe_pkg.sv =====
package gcpe_pkg;

   // Field widths of the stream payloads
   localparam int CHAR_W   = 8;
   localparam int GROW_W   = 5;
   localparam int BITS_W   = 8;
   localparam int COLOR_W  = 32;
   localparam int CELL_W   = 9;
   localparam int OFFSET_W = 26;
   localparam int LANES    = 8;
   localparam int KIND_W   = 2;

   // Configuration register widths
   localparam int PITCH_W = 13;
   localparam int FW_W    = 4;
   localparam int FH_W    = 6;

   // Request tdata layout, lowest field first
   localparam int REQ_CHAR_LO = 0;
   localparam int REQ_GROW_LO = REQ_CHAR_LO + CHAR_W;
   localparam int REQ_BITS_LO = REQ_GROW_LO + GROW_W;
   localparam int REQ_FG_LO   = REQ_BITS_LO + BITS_W;
   localparam int REQ_BG_LO   = REQ_FG_LO + COLOR_W;
   localparam int REQ_COL_LO  = REQ_BG_LO + COLOR_W;
   localparam int REQ_ROW_LO  = REQ_COL_LO + CELL_W;
   localparam int REQ_USED_W  = REQ_ROW_LO + CELL_W;
   localparam int REQ_TDATA_W = ((REQ_USED_W + 7) / 8) * 8;

   // Response tdata layout: offset, then eight lanes
   localparam int RSP_PIX_LO  = OFFSET_W;
   localparam int RSP_USED_W  = OFFSET_W + LANES * COLOR_W;
   localparam int RSP_TDATA_W = ((RSP_USED_W + 7) / 8) * 8;

   // Register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Reset values and default limits
   localparam logic [PITCH_W-1:0] PITCH_RESET  = 13'd1024;
   localparam logic [FW_W-1:0]    FW_RESET     = 4'd8;
   localparam logic [FH_W-1:0]    FH_RESET     = 6'd16;
   localparam logic [COLOR_W-1:0] CURSOR_RESET = 32'h00FF_FFFF;

   localparam int DEF_CHAR_COUNT      = 256;
   localparam int DEF_MAX_FONT_HEIGHT = 32;
   localparam int DEF_MAX_FONT_WIDTH  = 8;
   localparam int DEF_MAX_PITCH       = 4096;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD_GLYPH  = 2'd0,
      KIND_LOAD_CURSOR = 2'd1,
      KIND_DRAW        = 2'd2,
      KIND_DRAW_CURSOR = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      REG_PITCH  = 2'd0,
      REG_FW     = 2'd1,
      REG_FH     = 2'd2,
      REG_CURSOR = 2'd3
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_BASE,
      ST_ROWS
   } state_type;

   typedef struct packed {
      logic [PITCH_W-1:0] pitch;
      logic [FW_W-1:0]    font_width;
      logic [FH_W-1:0]    font_height;
      logic [COLOR_W-1:0] cursor_rgb;
   } cfg_type;

   // One glyph row handed from the sequencer to the output stage
   typedef struct packed {
      logic                load;
      logic [OFFSET_W-1:0] offset;
      logic                last;
      logic                cursor_mode;
      logic                char_ok;
      logic [COLOR_W-1:0]  fg;
      logic [COLOR_W-1:0]  bg;
   } row_ctl_type;

   typedef struct packed {
      logic busy;
      logic rd_pend;
      logic issue;
   } seq_status_type;

endpackage

// ===== design/gcpe_ram.sv =====
module gcpe_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 8,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/gcpe_csr.sv =====
module gcpe_csr #(
   parameter int MAX_FONT_WIDTH  = gcpe_pkg::DEF_MAX_FONT_WIDTH,
   parameter int MAX_FONT_HEIGHT = gcpe_pkg::DEF_MAX_FONT_HEIGHT,
   parameter int MAX_PITCH       = gcpe_pkg::DEF_MAX_PITCH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gcpe_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [gcpe_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [gcpe_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output gcpe_pkg::cfg_type                   cfg
);

   gcpe_pkg::cfg_type     cfg_ff, cfg_in;
   gcpe_pkg::csr_reg_type reg_sel;
   logic                  wr_strobe;
   logic [gcpe_pkg::PITCH_W-1:0] pitch_raw, pitch_clamped;
   logic [gcpe_pkg::FW_W-1:0]    fw_raw, fw_clamped;
   logic [gcpe_pkg::FH_W-1:0]    fh_raw, fh_clamped;

   assign csr_pready = 1'b1;
   assign reg_sel    = gcpe_pkg::csr_reg_type'(csr_paddr[3:2]);
   assign wr_strobe  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // clamp written values into their legal ranges
   assign pitch_raw = csr_pwdata[gcpe_pkg::PITCH_W-1:0];
   assign fw_raw    = csr_pwdata[gcpe_pkg::FW_W-1:0];
   assign fh_raw    = csr_pwdata[gcpe_pkg::FH_W-1:0];

   always_comb begin
      if (pitch_raw == '0) begin
         pitch_clamped = gcpe_pkg::PITCH_W'(1);
      end else if (pitch_raw > gcpe_pkg::PITCH_W'(MAX_PITCH)) begin
         pitch_clamped = gcpe_pkg::PITCH_W'(MAX_PITCH);
      end else begin
         pitch_clamped = pitch_raw;
      end
      if (fw_raw == '0) begin
         fw_clamped = gcpe_pkg::FW_W'(1);
      end else if (fw_raw > gcpe_pkg::FW_W'(MAX_FONT_WIDTH)) begin
         fw_clamped = gcpe_pkg::FW_W'(MAX_FONT_WIDTH);
      end else begin
         fw_clamped = fw_raw;
      end
      if (fh_raw == '0) begin
         fh_clamped = gcpe_pkg::FH_W'(1);
      end else if (fh_raw > gcpe_pkg::FH_W'(MAX_FONT_HEIGHT)) begin
         fh_clamped = gcpe_pkg::FH_W'(MAX_FONT_HEIGHT);
      end else begin
         fh_clamped = fh_raw;
      end
   end

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         case (reg_sel)
            gcpe_pkg::REG_PITCH:  cfg_in.pitch       = pitch_clamped;
            gcpe_pkg::REG_FW:     cfg_in.font_width  = fw_clamped;
            gcpe_pkg::REG_FH:     cfg_in.font_height = fh_clamped;
            gcpe_pkg::REG_CURSOR: cfg_in.cursor_rgb  = csr_pwdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pitch       <= gcpe_pkg::PITCH_RESET;
         cfg_ff.font_width  <= gcpe_pkg::FW_RESET;
         cfg_ff.font_height <= gcpe_pkg::FH_RESET;
         cfg_ff.cursor_rgb  <= gcpe_pkg::CURSOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         gcpe_pkg::REG_PITCH:  csr_prdata = gcpe_pkg::CSR_DATA_W'(cfg_ff.pitch);
         gcpe_pkg::REG_FW:     csr_prdata = gcpe_pkg::CSR_DATA_W'(cfg_ff.font_width);
         gcpe_pkg::REG_FH:     csr_prdata = gcpe_pkg::CSR_DATA_W'(cfg_ff.font_height);
         gcpe_pkg::REG_CURSOR: csr_prdata = cfg_ff.cursor_rgb;
         default:              csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/gcpe_seq.sv =====
module gcpe_seq #(
   parameter int CHAR_COUNT      = gcpe_pkg::DEF_CHAR_COUNT,
   parameter int MAX_FONT_HEIGHT = gcpe_pkg::DEF_MAX_FONT_HEIGHT,
   parameter int GLYPH_AW        = 13,
   parameter int CUR_AW          = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [gcpe_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [gcpe_pkg::KIND_W-1:0]          req_tuser,
   input  gcpe_pkg::cfg_type                    cfg,
   input  logic                                 out_free,
   output logic                                 glyph_wr_en,
   output logic [GLYPH_AW-1:0]                  glyph_wr_addr,
   output logic                                 cur_wr_en,
   output logic [CUR_AW-1:0]                    cur_wr_addr,
   output logic [gcpe_pkg::BITS_W-1:0]          wr_bits,
   output logic                                 rd_en,
   output logic [GLYPH_AW-1:0]                  glyph_rd_addr,
   output logic [CUR_AW-1:0]                    cur_rd_addr,
   output gcpe_pkg::row_ctl_type                row_ctl,
   output gcpe_pkg::seq_status_type             status
);

   localparam int LINE_W = gcpe_pkg::CELL_W + gcpe_pkg::FH_W;
   localparam int COLX_W = gcpe_pkg::CELL_W + gcpe_pkg::FW_W;
   localparam int PROD_W = LINE_W + gcpe_pkg::PITCH_W;

   gcpe_pkg::state_type    state_ff, state_in;
   gcpe_pkg::req_kind_type kind;

   logic [gcpe_pkg::CHAR_W-1:0]  ch;
   logic [gcpe_pkg::GROW_W-1:0]  grow;
   logic [gcpe_pkg::CELL_W-1:0]  col, row;
   logic                         req_acc, is_draw, char_in_range, grow_in_range;
   logic                         issue, last_issue;

   logic [gcpe_pkg::CELL_W-1:0]   col_ff, cellrow_ff;
   logic [LINE_W-1:0]             line_ff;
   logic [COLX_W-1:0]             colx_ff;
   logic [PROD_W-1:0]             line_prod;
   logic [gcpe_pkg::OFFSET_W-1:0] off_ff, off_in;
   logic [gcpe_pkg::FH_W-1:0]     row_ff, row_in;
   logic [GLYPH_AW-1:0]           char_base_ff;
   logic                          char_ok_ff, cursor_mode_ff;
   logic [gcpe_pkg::COLOR_W-1:0]  fg_ff, bg_ff;
   logic                          rd_pend_ff, rd_pend_in;
   logic [gcpe_pkg::OFFSET_W-1:0] pend_off_ff;
   logic                          pend_last_ff;
   logic [gcpe_pkg::COLOR_W-1:0]  pend_fg_ff, pend_bg_ff;
   logic                          pend_cursor_ff, pend_char_ok_ff;

   // request field unpack
   assign kind = gcpe_pkg::req_kind_type'(req_tuser);
   assign ch   = req_tdata[gcpe_pkg::REQ_CHAR_LO +: gcpe_pkg::CHAR_W];
   assign grow = req_tdata[gcpe_pkg::REQ_GROW_LO +: gcpe_pkg::GROW_W];
   assign col  = req_tdata[gcpe_pkg::REQ_COL_LO +: gcpe_pkg::CELL_W];
   assign row  = req_tdata[gcpe_pkg::REQ_ROW_LO +: gcpe_pkg::CELL_W];

   assign req_acc       = req_tvalid & req_tready;
   assign is_draw       = (kind == gcpe_pkg::KIND_DRAW) | (kind == gcpe_pkg::KIND_DRAW_CURSOR);
   assign char_in_range = 9'(ch) < 9'(CHAR_COUNT);
   assign grow_in_range = 6'(grow) < 6'(MAX_FONT_HEIGHT);

   // store loads write on the accepted transfer in idle
   assign wr_bits       = req_tdata[gcpe_pkg::REQ_BITS_LO +: gcpe_pkg::BITS_W];
   assign glyph_wr_en   = req_acc & (kind == gcpe_pkg::KIND_LOAD_GLYPH)
                          & char_in_range & grow_in_range;
   assign glyph_wr_addr = GLYPH_AW'(32'(ch) * 32'(MAX_FONT_HEIGHT) + 32'(grow));
   assign cur_wr_en     = req_acc & (kind == gcpe_pkg::KIND_LOAD_CURSOR) & grow_in_range;
   assign cur_wr_addr   = grow[CUR_AW-1:0];

   assign last_issue = (row_ff == cfg.font_height - gcpe_pkg::FH_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gcpe_pkg::ST_IDLE:  if (req_acc && is_draw) state_in = gcpe_pkg::ST_SCALE;
         gcpe_pkg::ST_SCALE: state_in = gcpe_pkg::ST_BASE;
         gcpe_pkg::ST_BASE:  state_in = gcpe_pkg::ST_ROWS;
         gcpe_pkg::ST_ROWS:  if (issue && last_issue) state_in = gcpe_pkg::ST_IDLE;
         default:            state_in = gcpe_pkg::ST_IDLE;
      endcase
   end

   // state outputs: a new read only when its data has a place to go
   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      case (state_ff)
         gcpe_pkg::ST_IDLE: req_tready = 1'b1;
         gcpe_pkg::ST_ROWS: issue = ~rd_pend_ff | out_free;
         default: begin
            req_tready = 1'b0;
            issue      = 1'b0;
         end
      endcase
   end

   assign rd_en         = issue;
   assign glyph_rd_addr = char_base_ff + GLYPH_AW'(row_ff);
   assign cur_rd_addr   = row_ff[CUR_AW-1:0];

   assign rd_pend_in = issue | (rd_pend_ff & ~out_free);

   // offset: line*pitch once per cell, then one pitch per glyph row
   assign line_prod = PROD_W'(line_ff) * PROD_W'(cfg.pitch);

   always_comb begin
      off_in = off_ff;
      row_in = row_ff;
      if (state_ff == gcpe_pkg::ST_BASE) begin
         off_in = gcpe_pkg::OFFSET_W'(line_prod) + gcpe_pkg::OFFSET_W'(colx_ff);
         row_in = '0;
      end else if (issue) begin
         off_in = off_ff + gcpe_pkg::OFFSET_W'(cfg.pitch);
         row_in = row_ff + gcpe_pkg::FH_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gcpe_pkg::ST_IDLE;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   // draw context and per-row payload; the row context travels with each
   // read so a new draw can be taken while the last row still waits
   always_ff @(posedge clock) begin
      if (req_acc && is_draw) begin
         col_ff         <= col;
         cellrow_ff     <= row;
         char_base_ff   <= GLYPH_AW'(32'(ch) * 32'(MAX_FONT_HEIGHT));
         char_ok_ff     <= char_in_range;
         cursor_mode_ff <= (kind == gcpe_pkg::KIND_DRAW_CURSOR);
         fg_ff          <= req_tdata[gcpe_pkg::REQ_FG_LO +: gcpe_pkg::COLOR_W];
         bg_ff          <= req_tdata[gcpe_pkg::REQ_BG_LO +: gcpe_pkg::COLOR_W];
      end
      if (state_ff == gcpe_pkg::ST_SCALE) begin
         line_ff <= LINE_W'(cellrow_ff) * LINE_W'(cfg.font_height);
         colx_ff <= COLX_W'(col_ff) * COLX_W'(cfg.font_width);
      end
      off_ff <= off_in;
      row_ff <= row_in;
      if (issue) begin
         pend_off_ff     <= off_ff;
         pend_last_ff    <= last_issue;
         pend_fg_ff      <= fg_ff;
         pend_bg_ff      <= bg_ff;
         pend_cursor_ff  <= cursor_mode_ff;
         pend_char_ok_ff <= char_ok_ff;
      end
   end

   assign row_ctl.load        = rd_pend_ff & out_free;
   assign row_ctl.offset      = pend_off_ff;
   assign row_ctl.last        = pend_last_ff;
   assign row_ctl.cursor_mode = pend_cursor_ff;
   assign row_ctl.char_ok     = pend_char_ok_ff;
   assign row_ctl.fg          = pend_fg_ff;
   assign row_ctl.bg          = pend_bg_ff;

   assign status.busy    = (state_ff != gcpe_pkg::ST_IDLE);
   assign status.rd_pend = rd_pend_ff;
   assign status.issue   = issue;

endmodule

// ===== design/gcpe_out.sv =====
module gcpe_out (
   input  logic                              clock,
   input  logic                              reset,
   input  gcpe_pkg::row_ctl_type             row_ctl,
   input  logic [gcpe_pkg::BITS_W-1:0]       glyph_bits,
   input  logic [gcpe_pkg::BITS_W-1:0]       cursor_bits,
   input  gcpe_pkg::cfg_type                 cfg,
   output logic                              out_free,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gcpe_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast
);

   logic                              valid_ff, valid_in;
   logic [gcpe_pkg::RSP_TDATA_W-1:0]  data_ff, data_in;
   logic                              last_ff;
   logic [gcpe_pkg::BITS_W-1:0]       gbits, cbits;

   assign out_free = ~valid_ff | rsp_tready;
   assign gbits    = row_ctl.char_ok ? glyph_bits : '0;
   assign cbits    = row_ctl.cursor_mode ? cursor_bits : '0;

   // lane j takes glyph bit 7-j; cursor wins over the character bit
   always_comb begin
      data_in = '0;
      data_in[gcpe_pkg::OFFSET_W-1:0] = row_ctl.offset;
      for (int j = 0; j < gcpe_pkg::LANES; j++) begin
         if (gcpe_pkg::FW_W'(j) < cfg.font_width) begin
            if (cbits[gcpe_pkg::LANES-1-j]) begin
               data_in[gcpe_pkg::RSP_PIX_LO + j*gcpe_pkg::COLOR_W +: gcpe_pkg::COLOR_W] =
                  cfg.cursor_rgb;
            end else if (gbits[gcpe_pkg::LANES-1-j]) begin
               data_in[gcpe_pkg::RSP_PIX_LO + j*gcpe_pkg::COLOR_W +: gcpe_pkg::COLOR_W] =
                  row_ctl.fg;
            end else begin
               data_in[gcpe_pkg::RSP_PIX_LO + j*gcpe_pkg::COLOR_W +: gcpe_pkg::COLOR_W] =
                  row_ctl.bg;
            end
         end
      end
   end

   assign valid_in = row_ctl.load | (valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (row_ctl.load) begin
         data_ff <= data_in;
         last_ff <= row_ctl.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== design/glyph_cell_pixel_expander.sv =====
// Text-cell renderer.
// req channel: tuser is the item kind (load glyph row, load cursor row, draw
// cell, draw cell with cursor). Loads write one 8-bit row into the glyph
// store or the cursor store.
// A draw produces font_height transfers on rsp, one per glyph row, each with
// the framebuffer pixel offset and eight lane colors; tlast marks last row.
// The first row passes the SCALE and BASE states (offset multiply), the glyph
// memory read and the output register. A draw holds the input closed until
// its last row read issues; rows leave at one per cycle while rsp is ready,
// limited by the single read port of the glyph memory. If rsp stalls, one
// row waits in the output register and one in the memory read register; row
// reads stop until the output drains, nothing is lost. Reset returns the
// sequencer to idle, empties the output stage and loads the register defaults;
// store contents are not cleared, undefined until loaded. The user must write
// configuration through the csr port while idle; the block does not check it.
module glyph_cell_pixel_expander #(
   parameter int CHAR_COUNT      = gcpe_pkg::DEF_CHAR_COUNT,
   parameter int MAX_FONT_HEIGHT = gcpe_pkg::DEF_MAX_FONT_HEIGHT,
   parameter int MAX_FONT_WIDTH  = gcpe_pkg::DEF_MAX_FONT_WIDTH,
   parameter int MAX_PITCH       = gcpe_pkg::DEF_MAX_PITCH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // char_code, glyph_row, row_bits, fg_color, bg_color, cell_col, cell_row
   input  logic [gcpe_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_type
   input  logic [gcpe_pkg::KIND_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pixel_offset, pixel_0 .. pixel_7
   output logic [gcpe_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gcpe_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [gcpe_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [gcpe_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int GLYPH_DEPTH = CHAR_COUNT * MAX_FONT_HEIGHT;
   localparam int GLYPH_AW    = (GLYPH_DEPTH > 1) ? $clog2(GLYPH_DEPTH) : 1;
   localparam int CUR_AW      = (MAX_FONT_HEIGHT > 1) ? $clog2(MAX_FONT_HEIGHT) : 1;

   gcpe_pkg::cfg_type        cfg;
   gcpe_pkg::row_ctl_type    row_ctl;
   gcpe_pkg::seq_status_type status;

   logic                          out_free;
   logic                          glyph_wr_en, cur_wr_en, rd_en;
   logic [GLYPH_AW-1:0]           glyph_wr_addr, glyph_rd_addr;
   logic [CUR_AW-1:0]             cur_wr_addr, cur_rd_addr;
   logic [gcpe_pkg::BITS_W-1:0]   wr_bits, glyph_bits, cursor_bits;

   gcpe_csr #(
      .MAX_FONT_WIDTH  (MAX_FONT_WIDTH),
      .MAX_FONT_HEIGHT (MAX_FONT_HEIGHT),
      .MAX_PITCH       (MAX_PITCH)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gcpe_seq #(
      .CHAR_COUNT      (CHAR_COUNT),
      .MAX_FONT_HEIGHT (MAX_FONT_HEIGHT),
      .GLYPH_AW        (GLYPH_AW),
      .CUR_AW          (CUR_AW)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .cfg           (cfg),
      .out_free      (out_free),
      .glyph_wr_en   (glyph_wr_en),
      .glyph_wr_addr (glyph_wr_addr),
      .cur_wr_en     (cur_wr_en),
      .cur_wr_addr   (cur_wr_addr),
      .wr_bits       (wr_bits),
      .rd_en         (rd_en),
      .glyph_rd_addr (glyph_rd_addr),
      .cur_rd_addr   (cur_rd_addr),
      .row_ctl       (row_ctl),
      .status        (status)
   );

   // glyph rows, addressed char * MAX_FONT_HEIGHT + row
   gcpe_ram #(
      .DEPTH (GLYPH_DEPTH),
      .WIDTH (gcpe_pkg::BITS_W),
      .AW    (GLYPH_AW)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (glyph_wr_en),
      .wr_addr (glyph_wr_addr),
      .wr_data (wr_bits),
      .rd_en   (rd_en),
      .rd_addr (glyph_rd_addr),
      .rd_data (glyph_bits)
   );

   gcpe_ram #(
      .DEPTH (MAX_FONT_HEIGHT),
      .WIDTH (gcpe_pkg::BITS_W),
      .AW    (CUR_AW)
   ) u_cursor_ram (
      .clock   (clock),
      .wr_en   (cur_wr_en),
      .wr_addr (cur_wr_addr),
      .wr_data (wr_bits),
      .rd_en   (rd_en),
      .rd_addr (cur_rd_addr),
      .rd_data (cursor_bits)
   );

   gcpe_out u_out (
      .clock       (clock),
      .reset       (reset),
      .row_ctl     (row_ctl),
      .glyph_bits  (glyph_bits),
      .cursor_bits (cursor_bits),
      .cfg         (cfg),
      .out_free    (out_free),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   // a held read result must not be overwritten by a new read
   a_no_read_over_held: assert property (@(posedge clock) disable iff (reset)
      (status.rd_pend && !out_free) |-> !rd_en)
      else $error("glyph read issued while previous row is still held");

   // row reads only happen while a draw owns the block
   a_read_while_busy: assert property (@(posedge clock) disable iff (reset)
      status.issue |-> (status.busy && !req_tready))
      else $error("glyph read outside a draw");

   // a draw transfer closes the input for the following cycle
   a_draw_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[1]) |=> !req_tready)
      else $error("input still open after draw transfer");

   // the output stage is empty after reset
   a_reset_empties_output: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

// ===== test/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 60_000;
   localparam int IDLE_PCT     = 13;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 50;
   localparam int STORE_DEPTH  = gcpe_pkg::DEF_CHAR_COUNT * gcpe_pkg::DEF_MAX_FONT_HEIGHT;

   // One request item, fields as they travel on req
   typedef struct {
      gcpe_pkg::req_kind_type               kind;
      logic [gcpe_pkg::CHAR_W-1:0]          char_code;
      logic [gcpe_pkg::GROW_W-1:0]          glyph_row;
      logic [gcpe_pkg::BITS_W-1:0]          row_bits;
      logic [gcpe_pkg::COLOR_W-1:0]         fg;
      logic [gcpe_pkg::COLOR_W-1:0]         bg;
      logic [gcpe_pkg::CELL_W-1:0]          col;
      logic [gcpe_pkg::CELL_W-1:0]          row;
   } cell_req_type;

   // One rendered glyph row as it should leave on rsp
   typedef struct packed {
      logic [gcpe_pkg::OFFSET_W-1:0]                      offset;
      logic [gcpe_pkg::LANES-1:0][gcpe_pkg::COLOR_W-1:0]  pixel;
      logic                                               last;
   } pixel_row_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   // char_code, glyph_row, row_bits, fg_color, bg_color, cell_col, cell_row
   logic [gcpe_pkg::REQ_TDATA_W-1:0]      req_tdata = '0;
   // req_type
   logic [gcpe_pkg::KIND_W-1:0]           req_tuser = '0;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   // pixel_offset, pixel_0 .. pixel_7
   logic [gcpe_pkg::RSP_TDATA_W-1:0]      rsp_tdata;
   logic                                  rsp_tlast;
   logic                                  csr_psel = 1'b0;
   logic                                  csr_penable = 1'b0;
   logic                                  csr_pwrite = 1'b0;
   logic [gcpe_pkg::CSR_ADDR_W-1:0]       csr_paddr = '0;
   logic [gcpe_pkg::CSR_DATA_W-1:0]       csr_pwdata = '0;
   logic [gcpe_pkg::CSR_DATA_W-1:0]       csr_prdata;
   logic                                  csr_pready;

   // Predictor state: stores, configuration, rows still to arrive
   logic [gcpe_pkg::BITS_W-1:0]   font_rows [STORE_DEPTH];
   bit                            font_loaded [STORE_DEPTH];
   logic [gcpe_pkg::BITS_W-1:0]   cursor_rows [gcpe_pkg::DEF_MAX_FONT_HEIGHT];
   bit                            char_ready [gcpe_pkg::DEF_CHAR_COUNT];
   logic [gcpe_pkg::CHAR_W-1:0]   ready_chars [$];
   int unsigned                   pitch_px;
   int unsigned                   font_w;
   int unsigned                   font_h;
   logic [gcpe_pkg::COLOR_W-1:0]  cursor_px;
   pixel_row_type                 pending_rows [$];

   int  err_count = 0;
   int  cycle_count = 0;
   bit  steady_flow = 1'b0;

   glyph_cell_pixel_expander dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Random backpressure on rsp, none while steady_flow is set
   always @(negedge clock) begin
      rsp_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
   end

   function automatic void flag_error(string msg);
      err_count++;
      if (err_count <= MAX_REPORTS) $error("%s", msg);
   endfunction

   function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Register write as the block sees it: field masked to width, then clamped
   function automatic void apply_csr(gcpe_pkg::csr_reg_type idx,
                                     logic [gcpe_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         gcpe_pkg::REG_PITCH: begin
            pitch_px = clamp_to(32'(data[gcpe_pkg::PITCH_W-1:0]), gcpe_pkg::DEF_MAX_PITCH);
         end
         gcpe_pkg::REG_FW: begin
            font_w = clamp_to(32'(data[gcpe_pkg::FW_W-1:0]), gcpe_pkg::DEF_MAX_FONT_WIDTH);
         end
         gcpe_pkg::REG_FH: begin
            font_h = clamp_to(32'(data[gcpe_pkg::FH_W-1:0]), gcpe_pkg::DEF_MAX_FONT_HEIGHT);
         end
         gcpe_pkg::REG_CURSOR: begin
            cursor_px = data;
         end
         default: begin
         end
      endcase
   endfunction

   // Loads update the stores; draws queue one expected row per glyph row
   function automatic void predict_item(cell_req_type it);
      pixel_row_type                 w;
      logic [gcpe_pkg::BITS_W-1:0]   gbits;
      logic [gcpe_pkg::BITS_W-1:0]   cbits;
      logic [63:0]                   off;
      case (it.kind)
         gcpe_pkg::KIND_LOAD_GLYPH: begin
            font_rows[{it.char_code, it.glyph_row}] = it.row_bits;
         end
         gcpe_pkg::KIND_LOAD_CURSOR: begin
            cursor_rows[it.glyph_row] = it.row_bits;
         end
         default: begin
            for (int unsigned i = 0; i < font_h; i++) begin
               gbits = font_rows[{it.char_code, gcpe_pkg::GROW_W'(i)}];
               cbits = (it.kind == gcpe_pkg::KIND_DRAW_CURSOR) ?
                       cursor_rows[gcpe_pkg::GROW_W'(i)] : '0;
               off = (64'(it.row) * 64'(font_h) + 64'(i)) * 64'(pitch_px)
                     + 64'(it.col) * 64'(font_w);
               w.offset = off[gcpe_pkg::OFFSET_W-1:0];
               for (int j = 0; j < gcpe_pkg::LANES; j++) begin
                  // lane 0 is the MSB of the glyph row
                  if (j >= font_w) w.pixel[j] = '0;
                  else if (cbits[gcpe_pkg::BITS_W-1-j]) w.pixel[j] = cursor_px;
                  else if (gbits[gcpe_pkg::BITS_W-1-j]) w.pixel[j] = it.fg;
                  else w.pixel[j] = it.bg;
               end
               w.last = (i + 1 == font_h);
               pending_rows.push_back(w);
            end
         end
      endcase
   endfunction

   // Compare each rsp transfer with the oldest pending row
   always @(posedge clock) begin : check_rsp
      pixel_row_type                 want;
      logic [gcpe_pkg::COLOR_W-1:0]  got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rows.size() == 0) begin
            flag_error("rsp transfer with no row pending");
         end else begin
            want = pending_rows.pop_front();
            if (rsp_tdata[gcpe_pkg::OFFSET_W-1:0] !== want.offset)
               flag_error($sformatf("pixel_offset: expected %h, got %h",
                  want.offset, rsp_tdata[gcpe_pkg::OFFSET_W-1:0]));
            for (int j = 0; j < gcpe_pkg::LANES; j++) begin
               got = rsp_tdata[gcpe_pkg::RSP_PIX_LO + j*gcpe_pkg::COLOR_W +: gcpe_pkg::COLOR_W];
               if (got !== want.pixel[j])
                  flag_error($sformatf("pixel_%0d: expected %h, got %h",
                     j, want.pixel[j], got));
            end
            if (rsp_tlast !== want.last)
               flag_error($sformatf("last_row: expected %b, got %b",
                  want.last, rsp_tlast));
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(cell_req_type it);
      logic [gcpe_pkg::REQ_TDATA_W-1:0] word;
      word = '0;
      word[gcpe_pkg::REQ_CHAR_LO +: gcpe_pkg::CHAR_W]  = it.char_code;
      word[gcpe_pkg::REQ_GROW_LO +: gcpe_pkg::GROW_W]  = it.glyph_row;
      word[gcpe_pkg::REQ_BITS_LO +: gcpe_pkg::BITS_W]  = it.row_bits;
      word[gcpe_pkg::REQ_FG_LO   +: gcpe_pkg::COLOR_W] = it.fg;
      word[gcpe_pkg::REQ_BG_LO   +: gcpe_pkg::COLOR_W] = it.bg;
      word[gcpe_pkg::REQ_COL_LO  +: gcpe_pkg::CELL_W]  = it.col;
      word[gcpe_pkg::REQ_ROW_LO  +: gcpe_pkg::CELL_W]  = it.row;
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      predict_item(it);
      @(negedge clock);
   endtask

   // Drop valid, wait for every pending row, then let the pipeline empty
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_rows.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Two-phase register write; leaves the bus idle after the access
   task automatic csr_write(gcpe_pkg::csr_reg_type idx,
                            logic [gcpe_pkg::CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      apply_csr(idx, data);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(logic [31:0] pitch, logic [31:0] fw, logic [31:0] fh,
                             logic [31:0] cursor);
      csr_write(gcpe_pkg::REG_PITCH, pitch);
      csr_write(gcpe_pkg::REG_FW, fw);
      csr_write(gcpe_pkg::REG_FH, fh);
      csr_write(gcpe_pkg::REG_CURSOR, cursor);
   endtask

   function automatic logic [gcpe_pkg::COLOR_W-1:0] pick_color();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [gcpe_pkg::CELL_W-1:0] pick_cell();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return gcpe_pkg::CELL_W'($urandom_range(511));
      endcase
   endfunction

   function automatic cell_req_type random_item(gcpe_pkg::req_kind_type kind);
      cell_req_type it;
      it.kind      = kind;
      it.char_code = gcpe_pkg::CHAR_W'($urandom_range(255));
      it.glyph_row = gcpe_pkg::GROW_W'($urandom_range(31));
      it.row_bits  = gcpe_pkg::BITS_W'($urandom_range(255));
      it.fg        = pick_color();
      it.bg        = pick_color();
      it.col       = pick_cell();
      it.row       = pick_cell();
      return it;
   endfunction

   function automatic cell_req_type draw_item(gcpe_pkg::req_kind_type kind,
                                              logic [gcpe_pkg::CHAR_W-1:0] ch,
                                              logic [gcpe_pkg::COLOR_W-1:0] fg,
                                              logic [gcpe_pkg::COLOR_W-1:0] bg,
                                              logic [gcpe_pkg::CELL_W-1:0] col,
                                              logic [gcpe_pkg::CELL_W-1:0] row);
      cell_req_type it;
      it = random_item(kind);
      it.char_code = ch;
      it.fg  = fg;
      it.bg  = bg;
      it.col = col;
      it.row = row;
      return it;
   endfunction

   // Load every glyph row of a character not yet written, so draws never
   // read an unwritten entry
   task automatic fill_glyph(logic [gcpe_pkg::CHAR_W-1:0] ch, bit fixed,
                             logic [gcpe_pkg::BITS_W-1:0] pattern);
      cell_req_type it;
      for (int r = 0; r < gcpe_pkg::DEF_MAX_FONT_HEIGHT; r++) begin
         if (!font_loaded[{ch, gcpe_pkg::GROW_W'(r)}]) begin
            it = random_item(gcpe_pkg::KIND_LOAD_GLYPH);
            it.char_code = ch;
            it.glyph_row = gcpe_pkg::GROW_W'(r);
            if (fixed) it.row_bits = pattern;
            font_loaded[{ch, gcpe_pkg::GROW_W'(r)}] = 1'b1;
            send_item(it);
         end
      end
      if (!char_ready[ch]) begin
         char_ready[ch] = 1'b1;
         ready_chars.push_back(ch);
      end
   endtask

   // Reset defaults: font preload, cursor glyph, a handful of draws
   task automatic test_default_config();
      cell_req_type it;
      fill_glyph(8'h00, 1'b1, 8'h00);
      fill_glyph(8'hFF, 1'b1, 8'hFF);
      fill_glyph(8'h41, 1'b0, 8'h00);
      for (int r = 0; r < gcpe_pkg::DEF_MAX_FONT_HEIGHT; r++) begin
         it = random_item(gcpe_pkg::KIND_LOAD_CURSOR);
         it.glyph_row = gcpe_pkg::GROW_W'(r);
         it.row_bits = (r % 4 == 3) ? 8'hFF : (8'h01 << (r % 8));
         send_item(it);
      end
      send_item(draw_item(gcpe_pkg::KIND_DRAW, 8'h41, '0, '1, 9'd0, 9'd0));
      send_item(draw_item(gcpe_pkg::KIND_DRAW, 8'hFF, '1, '0, 9'd511, 9'd511));
      send_item(draw_item(gcpe_pkg::KIND_DRAW, 8'h00, $urandom, $urandom, 9'd1, 9'd2));
      // load immediately followed by a draw of the same glyph
      it = random_item(gcpe_pkg::KIND_LOAD_GLYPH);
      it.char_code = 8'h41;
      it.glyph_row = 5'd3;
      it.row_bits  = 8'h3C;
      send_item(it);
      send_item(draw_item(gcpe_pkg::KIND_DRAW, 8'h41, $urandom, $urandom, 9'd17, 9'd9));
      send_item(draw_item(gcpe_pkg::KIND_DRAW_CURSOR, 8'h41, $urandom, $urandom,
                          9'd100, 9'd37));
      send_item(draw_item(gcpe_pkg::KIND_DRAW_CURSOR, 8'hFF, '0, '1, 9'd511, 9'd0));
      settle_block();
   endtask

   // Register extremes, clamping from both sides, a narrow odd font
   task automatic test_config_limits();
      set_config(32'd4096, 32'd8, 32'd32, 32'hFFFF_FFFF);
      send_item(draw_item(gcpe_pkg::KIND_DRAW, 8'hFF, $urandom, $urandom, 9'd511, 9'd511));
      send_item(draw_item(gcpe_pkg::KIND_DRAW_CURSOR, 8'h41, $urandom, $urandom,
                          9'd511, 9'd511));
      settle_block();

      set_config(32'd1, 32'd1, 32'd1, 32'h0);
      send_item(draw_item(gcpe_pkg::KIND_DRAW, 8'h41, $urandom, $urandom, 9'd0, 9'd0));
      send_item(draw_item(gcpe_pkg::KIND_DRAW_CURSOR, 8'h00, $urandom, $urandom,
                          9'd511, 9'd511));
      settle_block();

      // zero in the register field, junk above it: clamps up to one
      set_config(32'hFFFF_E000, 32'hFFFF_FFF0, 32'hFFFF_FFC0, 32'h1234_5678);
      send_item(draw_item(gcpe_pkg::KIND_DRAW, 8'hFF, $urandom, $urandom, 9'd300, 9'd200));
      settle_block();

      // field at its top value: clamps down to the maximum
      set_config(32'h0000_1FFF, 32'h0000_000F, 32'h0000_003F, 32'h8000_0001);
      send_item(draw_item(gcpe_pkg::KIND_DRAW_CURSOR, 8'h41, $urandom, $urandom,
                          9'd77, 9'd500));
      settle_block();

      set_config(32'd640, 32'd5, 32'd3, 32'h00A5_5A00);
      send_item(draw_item(gcpe_pkg::KIND_DRAW, 8'h41, $urandom, $urandom, 9'd79, 9'd24));
      send_item(draw_item(gcpe_pkg::KIND_DRAW_CURSOR, 8'hFF, $urandom, $urandom,
                          9'd3, 9'd4));
      settle_block();
   endtask

   task automatic random_config();
      logic [31:0] pitch;
      logic [31:0] fw;
      logic [31:0] fh;
      pitch = $urandom;
      fw    = $urandom;
      fh    = $urandom;
      case ($urandom_range(9))
         0: ;
         1: pitch[gcpe_pkg::PITCH_W-1:0] = 13'd4096;
         default: pitch[gcpe_pkg::PITCH_W-1:0] = gcpe_pkg::PITCH_W'($urandom_range(1, 4096));
      endcase
      case ($urandom_range(9))
         0: ;
         1: fh[gcpe_pkg::FH_W-1:0] = 6'd32;
         default: fh[gcpe_pkg::FH_W-1:0] = gcpe_pkg::FH_W'($urandom_range(1, 16));
      endcase
      set_config(pitch, fw, fh, pick_color());
   endtask

   // Phases of mixed loads and draws under random settings; one phase
   // runs with no idling on either side
   task automatic test_random_traffic();
      cell_req_type it;
      int           pick;
      for (int phase = 0; phase < 5; phase++) begin
         random_config();
         steady_flow = (phase == 2);
         for (int n = 0; n < 18; n++) begin
            pick = $urandom_range(99);
            if (pick < 18) begin
               it = random_item(gcpe_pkg::KIND_LOAD_GLYPH);
               if ($urandom_range(3) != 0)
                  it.char_code = ready_chars[$urandom_range(ready_chars.size() - 1)];
               font_loaded[{it.char_code, it.glyph_row}] = 1'b1;
               send_item(it);
            end else if (pick < 24) begin
               send_item(random_item(gcpe_pkg::KIND_LOAD_CURSOR));
            end else begin
               it = random_item($urandom_range(1) ? gcpe_pkg::KIND_DRAW_CURSOR :
                                                    gcpe_pkg::KIND_DRAW);
               it.char_code = ready_chars[$urandom_range(ready_chars.size() - 1)];
               fill_glyph(it.char_code, 1'b0, 8'h00);
               send_item(it);
            end
         end
         settle_block();
         steady_flow = 1'b0;
      end
   endtask

   initial begin
      pitch_px  = 32'(gcpe_pkg::PITCH_RESET);
      font_w    = 32'(gcpe_pkg::FW_RESET);
      font_h    = 32'(gcpe_pkg::FH_RESET);
      cursor_px = gcpe_pkg::CURSOR_RESET;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_default_config();
      test_config_limits();
      test_random_traffic();
      if (err_count == 0 && pending_rows.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
design/gcpe_pkg.sv
design/gcpe_ram.sv
design/gcpe_csr.sv
design/gcpe_seq.sv
design/gcpe_out.sv
design/glyph_cell_pixel_expander.sv
test/tb_top.sv
